/* src/vfcm_pkg.sv */
`timescale 1ns / 1ps

package vfcm_pkg;

  localparam int WIDTH  = 16;
  localparam int HEIGHT = 64;
  localparam int LENGTH = 16;

  localparam int X_W    = 4;
  localparam int Y_W    = 6;
  localparam int Z_W    = 4;
  localparam int DEPTH  = WIDTH * HEIGHT * LENGTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int VC_W   = 17;
  localparam int WC_W   = 16;
  localparam int ORG_W  = 12;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_MESH  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] KIND_AIR   = 2'd0;
  localparam logic [1:0] KIND_UNDEF = 2'd3;

  localparam logic REG_ORIGIN_X = 1'b0;
  localparam logic REG_ORIGIN_Z = 1'b1;

  localparam logic [2:0] FACE_FRONT  = 3'd0;
  localparam logic [2:0] FACE_BACK   = 3'd1;
  localparam logic [2:0] FACE_RIGHT  = 3'd2;
  localparam logic [2:0] FACE_LEFT   = 3'd3;
  localparam logic [2:0] FACE_TOP    = 3'd4;
  localparam logic [2:0] FACE_BOTTOM = 3'd5;

  localparam logic [1:0] TEX_SIDE = 2'd0;
  localparam logic [1:0] TEX_BACK = 2'd1;
  localparam logic [1:0] TEX_TOP  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } vfcm_state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        wdata;
  } store_req_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [X_W-1:0] x,
                                                   input logic [Y_W-1:0] y,
                                                   input logic [Z_W-1:0] z);
    return ADDR_W'(ADDR_W'(x) + ADDR_W'(WIDTH) *
                   (ADDR_W'(y) + ADDR_W'(HEIGHT) * ADDR_W'(z)));
  endfunction

  function automatic logic signed [1:0] face_dx(input logic [2:0] f);
    case (f)
      FACE_RIGHT: return 2'sd1;
      FACE_LEFT:  return -2'sd1;
      default:    return 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] face_dy(input logic [2:0] f);
    case (f)
      FACE_TOP:    return 2'sd1;
      FACE_BOTTOM: return -2'sd1;
      default:     return 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] face_dz(input logic [2:0] f);
    case (f)
      FACE_FRONT: return 2'sd1;
      FACE_BACK:  return -2'sd1;
      default:    return 2'sd0;
    endcase
  endfunction

  function automatic logic [1:0] face_tex(input logic [2:0] f);
    case (f)
      FACE_BACK:                 return TEX_BACK;
      FACE_TOP, FACE_BOTTOM:     return TEX_TOP;
      default:                   return TEX_SIDE;
    endcase
  endfunction

  function automatic logic [3:0] face_shade(input logic [2:0] f);
    case (f)
      FACE_FRONT, FACE_BACK: return 4'd6;
      FACE_RIGHT:            return 4'd4;
      FACE_LEFT:             return 4'd10;
      default:               return 4'd8;
    endcase
  endfunction

endpackage

/* src/vfcm_store.sv */
`timescale 1ns / 1ps

module vfcm_store (
  input  logic                  clk,
  input  vfcm_pkg::store_req_t  req,
  output logic [1:0]            rdata_r
);
  import vfcm_pkg::*;

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

endmodule

/* src/voxel_face_culling_mesher_unit.sv */
`timescale 1ns / 1ps

// Voxel face culling mesher.
// in_*  : stream of commands. tuser carries the function (write block, mesh block,
//         clear vertex count); tdata carries position and block kind.
// out_* : stream of face records, tlast on the final record of each mesh command,
//         tuser high when the record is a visible face.
// cfg_* : register port holding the chunk origin along x (0x0) and z (0x4).
// Write and clear commands keep in_tready high and give no record. A mesh command
// reads its own block and six neighbours from the single-port block store, one
// read a cycle, so in_tready is low through the reads and compares and while
// the records (one to six) are handed out. The last record may still wait in
// the output register while the next command is taken.
// A stalled receiver holds the record in the output register and the sequencer
// waits. Reset clears the vertex count, the origin registers and the output
// valid; block store contents are undefined until written.
module voxel_face_culling_mesher_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // pos_x, pos_y, pos_z, block_kind
  input  logic [1:0]  in_tuser,  // func

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata, // face_id, kind_out, tex_set, shade_tenths, world_x,
                                 // world_y, world_z, base_vertex, zero pad
  output logic [0:0]  out_tuser, // face_valid
  output logic        out_tlast,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import vfcm_pkg::*;

  vfcm_state_t state_r, state_nxt;

  logic signed [ORG_W-1:0] org_x_r, org_z_r;
  logic [X_W-1:0] px_r, px_nxt;
  logic [Y_W-1:0] py_r, py_nxt;
  logic [Z_W-1:0] pz_r, pz_nxt;
  logic [2:0]     idx_r, idx_nxt;
  logic           cmp_vld_r, cmp_vld_nxt;
  logic [2:0]     cmp_idx_r, cmp_idx_nxt;
  logic           cmp_inb_r, cmp_inb_nxt;
  logic [1:0]     kind_r, kind_nxt;
  logic [5:0]     mask_r, mask_nxt;
  logic [VC_W-1:0] vcount_r, vcount_nxt;

  logic            o_valid_r, o_valid_nxt;
  logic            o_fvalid_r, o_fvalid_nxt;
  logic [2:0]      o_face_r, o_face_nxt;
  logic [1:0]      o_kind_r, o_kind_nxt;
  logic [1:0]      o_tex_r, o_tex_nxt;
  logic [3:0]      o_shade_r, o_shade_nxt;
  logic [WC_W-1:0] o_wx_r, o_wx_nxt;
  logic [Y_W-1:0]  o_wy_r, o_wy_nxt;
  logic [WC_W-1:0] o_wz_r, o_wz_nxt;
  logic [VC_W-1:0] o_base_r, o_base_nxt;
  logic            o_last_r, o_last_nxt;

  logic            in_acc, out_acc, cfg_wr;
  logic [X_W-1:0]  in_x;
  logic [Y_W-1:0]  in_y;
  logic [Z_W-1:0]  in_z;
  logic [1:0]      in_kind;
  logic            in_inb;
  logic [2:0]      face;
  logic [X_W:0]    nx;
  logic [Y_W:0]    ny;
  logic [Z_W:0]    nz;
  logic            n_inb;
  logic [1:0]      rdata_r;
  logic            visible;
  logic [2:0]      pick;
  logic            found;
  logic [5:0]      rem;
  logic [WC_W-1:0] wx_c, wz_c;
  store_req_t      sreq;

  assign in_x    = in_tdata[3:0];
  assign in_y    = in_tdata[9:4];
  assign in_z    = in_tdata[13:10];
  assign in_kind = in_tdata[15:14];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = o_valid_r && out_tready;

  assign in_inb = ({1'b0, in_x} < (X_W+1)'(WIDTH)) && ({1'b0, in_y} < (Y_W+1)'(HEIGHT))
               && ({1'b0, in_z} < (Z_W+1)'(LENGTH));

  // neighbour address: step 0 reads the block itself, steps 1..6 the faces
  always_comb begin
    face = 3'(idx_r - 3'd1);
    if (idx_r == 3'd0) begin
      nx = {1'b0, px_r};
      ny = {1'b0, py_r};
      nz = {1'b0, pz_r};
    end else begin
      nx = {1'b0, px_r} + (X_W+1)'(face_dx(face));
      ny = {1'b0, py_r} + (Y_W+1)'(face_dy(face));
      nz = {1'b0, pz_r} + (Z_W+1)'(face_dz(face));
    end
    n_inb = (nx < (X_W+1)'(WIDTH)) && (ny < (Y_W+1)'(HEIGHT)) && (nz < (Z_W+1)'(LENGTH));
  end

  always_comb begin
    if (state_r == ST_IDLE) begin
      sreq.we    = in_acc && (in_tuser == FUNC_WRITE) && in_inb;
      sreq.addr  = store_addr(in_x, in_y, in_z);
      sreq.wdata = (in_kind == KIND_UNDEF) ? KIND_AIR : in_kind;
    end else begin
      sreq.we    = 1'b0;
      sreq.addr  = store_addr(nx[X_W-1:0], ny[Y_W-1:0], nz[Z_W-1:0]);
      sreq.wdata = KIND_AIR;
    end
  end

  vfcm_store u_store (
    .clk     (clk),
    .req     (sreq),
    .rdata_r (rdata_r)
  );

  assign visible = !cmp_inb_r || (rdata_r != kind_r);

  always_comb begin
    pick  = FACE_FRONT;
    found = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (mask_r[i] && !found) begin
        pick  = 3'(i);
        found = 1'b1;
      end
    end
    rem = mask_r & ~(6'b1 << pick);
  end

  assign wx_c = WC_W'(WC_W'(org_x_r) * WC_W'(WIDTH) + WC_W'(px_r));
  assign wz_c = WC_W'(WC_W'(org_z_r) * WC_W'(LENGTH) + WC_W'(pz_r));

  always_comb begin
    state_nxt    = state_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    pz_nxt       = pz_r;
    idx_nxt      = idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    cmp_inb_nxt  = cmp_inb_r;
    kind_nxt     = kind_r;
    mask_nxt     = mask_r;
    vcount_nxt   = vcount_r;
    o_valid_nxt  = o_valid_r && !out_acc;
    o_fvalid_nxt = o_fvalid_r;
    o_face_nxt   = o_face_r;
    o_kind_nxt   = o_kind_r;
    o_tex_nxt    = o_tex_r;
    o_shade_nxt  = o_shade_r;
    o_wx_nxt     = o_wx_r;
    o_wy_nxt     = o_wy_r;
    o_wz_nxt     = o_wz_r;
    o_base_nxt   = o_base_r;
    o_last_nxt   = o_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == FUNC_CLEAR)) begin
          vcount_nxt = '0;
        end
        if (in_acc && (in_tuser == FUNC_MESH)) begin
          px_nxt    = in_x;
          py_nxt    = in_y;
          pz_nxt    = in_z;
          idx_nxt   = 3'd0;
          mask_nxt  = '0;
          state_nxt = ST_READ;
          if (!in_inb) begin
            px_nxt = '0;
            py_nxt = '0;
            pz_nxt = '0;
          end
        end
      end
      ST_READ: begin
        if (idx_r <= 3'd6) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r;
          cmp_inb_nxt = n_inb;
          idx_nxt     = idx_r + 3'd1;
        end
        if (cmp_vld_r) begin
          if (cmp_idx_r == 3'd0) begin
            kind_nxt = cmp_inb_r ? rdata_r : KIND_AIR;
          end else begin
            mask_nxt[3'(cmp_idx_r - 3'd1)] = visible;
          end
          if (cmp_idx_r == 3'd6) begin
            if (kind_r == KIND_AIR) begin
              mask_nxt = '0;
            end
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!o_valid_r || out_tready) begin
          o_valid_nxt = 1'b1;
          o_kind_nxt  = kind_r;
          o_wx_nxt    = wx_c;
          o_wy_nxt    = py_r;
          o_wz_nxt    = wz_c;
          o_base_nxt  = vcount_r;
          if (mask_r == '0) begin
            o_fvalid_nxt = 1'b0;
            o_face_nxt   = FACE_FRONT;
            o_tex_nxt    = TEX_SIDE;
            o_shade_nxt  = 4'd0;
            o_last_nxt   = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            o_fvalid_nxt = 1'b1;
            o_face_nxt   = pick;
            o_tex_nxt    = face_tex(pick);
            o_shade_nxt  = face_shade(pick);
            o_last_nxt   = (rem == '0);
            mask_nxt     = rem;
            vcount_nxt   = vcount_r + VC_W'(4);
            if (rem == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // the out-of-chunk mesh position reads as air but keeps its own coordinates
  logic oob_r, oob_nxt;
  logic [X_W-1:0] qx_r;
  logic [Y_W-1:0] qy_r;
  logic [Z_W-1:0] qz_r;

  assign oob_nxt = (state_r == ST_IDLE) ? (in_acc && !in_inb) : oob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      vcount_r  <= '0;
      o_valid_r <= 1'b0;
      oob_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      vcount_r  <= vcount_nxt;
      o_valid_r <= o_valid_nxt;
      oob_r     <= oob_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pz_r       <= pz_nxt;
    idx_r      <= idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    cmp_inb_r  <= cmp_inb_nxt;
    kind_r     <= oob_r ? KIND_AIR : kind_nxt;
    mask_r     <= mask_nxt;
    o_fvalid_r <= o_fvalid_nxt;
    o_face_r   <= o_face_nxt;
    o_kind_r   <= o_kind_nxt;
    o_tex_r    <= o_tex_nxt;
    o_shade_r  <= o_shade_nxt;
    o_wx_r     <= o_wx_nxt;
    o_wy_r     <= o_wy_nxt;
    o_wz_r     <= o_wz_nxt;
    o_base_r   <= o_base_nxt;
    o_last_r   <= o_last_nxt;
    if (in_acc) begin
      qx_r <= in_x;
      qy_r <= in_y;
      qz_r <= in_z;
    end
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_z_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ORIGIN_X: org_x_r <= cfg_pwdata[ORG_W-1:0];
        REG_ORIGIN_Z: org_z_r <= cfg_pwdata[ORG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_ORIGIN_X: cfg_prdata = 32'({org_x_r});
      REG_ORIGIN_Z: cfg_prdata = 32'({org_z_r});
      default:      cfg_prdata = '0;
    endcase
  end

  logic [WC_W-1:0] ow_x, ow_z;
  logic [Y_W-1:0]  ow_y;

  assign ow_x = oob_r ? WC_W'(WC_W'(org_x_r) * WC_W'(WIDTH) + WC_W'(qx_r)) : o_wx_r;
  assign ow_y = oob_r ? qy_r : o_wy_r;
  assign ow_z = oob_r ? WC_W'(WC_W'(org_z_r) * WC_W'(LENGTH) + WC_W'(qz_r)) : o_wz_r;

  assign out_tvalid = o_valid_r;
  assign out_tuser  = o_fvalid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {6'd0, o_base_r, ow_z, ow_y, ow_x, o_shade_r, o_tex_r, o_kind_r,
                       o_face_r};

endmodule

/* src/vfcm_checker.sv */
`timescale 1ns / 1ps

module vfcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [0:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_pready
);
  import vfcm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out word dropped while stalled");

  a_mesh_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_MESH) |=> !in_tready)
    else $error("mesh word did not occupy the block");

  a_invalid_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("invalid face record not marked last");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("cfg pready low");

endmodule

bind voxel_face_culling_mesher_unit vfcm_checker u_vfcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);
